@@ design/perc_pkg.sv @@
`default_nettype none

package perc_pkg;

  // Table sizing
  localparam int MAX_PARTITIONS = 32;
  localparam int MAX_ENTRIES    = 128;

  // Field and counter widths
  localparam int LBA_W      = 48;
  localparam int GUID_W     = 64;
  localparam int STATUS_W   = 3;
  localparam int PNUM_W     = 8;
  localparam int STORED_W   = 6;
  localparam int PART_IDX_W = $clog2(MAX_PARTITIONS);
  localparam int CNT_W      = $clog2(MAX_PARTITIONS + 1);
  localparam int ENT_W      = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = LBA_W;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_ACCEPTED = 3'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY    = 3'd1;
  localparam logic [STATUS_W-1:0] ST_RANGE    = 3'd2;
  localparam logic [STATUS_W-1:0] ST_OVERLAP  = 3'd3;
  localparam logic [STATUS_W-1:0] ST_TOO_MANY = 3'd4;
  localparam logic [STATUS_W-1:0] ST_IGNORED  = 3'd5;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_WIN_LO = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WIN_HI = 2'd1;

  typedef struct packed {
    logic              new_table;
    logic [GUID_W-1:0] type_guid_high;
    logic [GUID_W-1:0] type_guid_low;
    logic [LBA_W-1:0]  lba_lo;
    logic [LBA_W-1:0]  lba_hi;
  } in_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [PNUM_W-1:0]   partition_number;
    logic [STORED_W-1:0] stored_count;
  } out_t;

endpackage

`default_nettype wire

@@ design/partition_entry_range_checker.sv @@
`default_nettype none

// Partition entry range checker.
// Input: one table entry per transfer on in_data, taken at a clock edge where
// start is high and busy is low. Set new_table on the first entry of a table to
// clear the stored ranges, the entry number and the latched error.
// Output: exactly one result per entry on out_data, marked by out_valid for a
// single cycle; the receiver cannot stall, so the result must be taken then.
// Configuration: cfg_we/cfg_index/cfg_wdata write the low (index 0) and high
// (index 1) bounds of the usable block window; other indexes are ignored.
// Write only while idle.
// Operation: the overlap check walks the stored ranges with one shared compare
// unit, one range per cycle, up to 32 of them. The entry is registered at the
// accepting edge, checked in S_PREP, scanned in S_SCAN, and out_valid and the
// result are registered at the end. busy falls in the cycle of the strobe and a
// new entry can be taken in that cycle; no entry is taken while one is in work.
// Reset (rst_n low, synchronous) clears the counters, the error flag and both
// window bounds; the range store itself is not cleared and is only read below
// the accepted count.
module partition_entry_range_checker (
  input  wire                                  clk,
  input  wire                                  rst_n,
  input  wire                                  start,
  output logic                                 busy,
  input  wire perc_pkg::in_t                   in_data,
  output logic                                 out_valid,
  output perc_pkg::out_t                       out_data,
  input  wire                                  cfg_we,
  input  wire  [perc_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire  [perc_pkg::CFG_DATA_W-1:0]      cfg_wdata
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_PREP,
    S_SCAN
  } state_t;

  state_t                            state_r, state_nxt;
  perc_pkg::in_t                     item_r, item_nxt;
  logic [perc_pkg::LBA_W-1:0]        win_lo_r, win_lo_nxt;
  logic [perc_pkg::LBA_W-1:0]        win_hi_r, win_hi_nxt;
  logic [perc_pkg::CNT_W-1:0]        acc_cnt_r, acc_cnt_nxt;
  logic [perc_pkg::ENT_W-1:0]        ent_cnt_r, ent_cnt_nxt;
  logic                              err_r, err_nxt;
  logic [perc_pkg::PART_IDX_W-1:0]   scan_r, scan_nxt;
  logic [perc_pkg::PNUM_W-1:0]       num_r, num_nxt;
  logic                              out_valid_r, out_valid_nxt;
  perc_pkg::out_t                    out_r, out_nxt;
  logic                              wr_en;

  // Stored ranges, one pair per accepted partition
  logic [perc_pkg::LBA_W-1:0] rs_r [perc_pkg::MAX_PARTITIONS];
  logic [perc_pkg::LBA_W-1:0] re_r [perc_pkg::MAX_PARTITIONS];

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // Sequencer and shared compare unit
  always_comb begin
    logic                          fin_v;
    logic                          decide_v;
    logic [perc_pkg::STATUS_W-1:0] st_v;
    logic [perc_pkg::PNUM_W-1:0]   num_v;
    logic                          range_bad_v;
    logic                          overlap_v;

    state_nxt     = state_r;
    item_nxt      = item_r;
    win_lo_nxt    = win_lo_r;
    win_hi_nxt    = win_hi_r;
    acc_cnt_nxt   = acc_cnt_r;
    ent_cnt_nxt   = ent_cnt_r;
    err_nxt       = err_r;
    scan_nxt      = scan_r;
    num_nxt       = num_r;
    out_valid_nxt = 1'b0;
    out_nxt       = out_r;
    wr_en         = 1'b0;
    fin_v         = 1'b0;
    decide_v      = 1'b0;
    st_v          = perc_pkg::ST_IGNORED;
    num_v         = num_r;

    range_bad_v = (item_r.lba_lo > item_r.lba_hi) ||
                  (item_r.lba_lo < win_lo_r) ||
                  (item_r.lba_hi > win_hi_r);
    overlap_v   = !((item_r.lba_hi < rs_r[scan_r]) ||
                    (item_r.lba_lo > re_r[scan_r]));

    // Configuration writes
    if (cfg_we) begin
      unique case (cfg_index)
        perc_pkg::REG_WIN_LO: win_lo_nxt = cfg_wdata;
        perc_pkg::REG_WIN_HI: win_hi_nxt = cfg_wdata;
        default: ;
      endcase
    end

    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          item_nxt  = in_data;
          state_nxt = S_PREP;
          if (in_data.new_table) begin
            acc_cnt_nxt = '0;
            ent_cnt_nxt = '0;
            err_nxt     = 1'b0;
          end
        end
      end
      S_PREP: begin
        if (ent_cnt_r >= perc_pkg::ENT_W'(perc_pkg::MAX_ENTRIES)) begin
          fin_v = 1'b1;
          st_v  = perc_pkg::ST_IGNORED;
        end else begin
          ent_cnt_nxt = ent_cnt_r + 1'b1;
          num_nxt     = ent_cnt_r + 1'b1;
          num_v       = ent_cnt_r + 1'b1;
          if (err_r) begin
            fin_v = 1'b1;
            st_v  = perc_pkg::ST_IGNORED;
          end else if ((item_r.type_guid_high == '0) && (item_r.type_guid_low == '0)) begin
            fin_v = 1'b1;
            st_v  = perc_pkg::ST_EMPTY;
          end else if (range_bad_v) begin
            fin_v   = 1'b1;
            st_v    = perc_pkg::ST_RANGE;
            err_nxt = 1'b1;
          end else if (acc_cnt_r == '0) begin
            decide_v = 1'b1;
          end else begin
            scan_nxt  = '0;
            state_nxt = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (overlap_v) begin
          fin_v   = 1'b1;
          st_v    = perc_pkg::ST_OVERLAP;
          err_nxt = 1'b1;
        end else if (perc_pkg::CNT_W'(scan_r) + 1'b1 == acc_cnt_r) begin
          decide_v = 1'b1;
        end else begin
          scan_nxt = scan_r + 1'b1;
        end
      end
      default: state_nxt = S_IDLE;
    endcase

    // Last check after a clean scan: room left in the table
    if (decide_v) begin
      fin_v = 1'b1;
      if (acc_cnt_r >= perc_pkg::CNT_W'(perc_pkg::MAX_PARTITIONS)) begin
        st_v    = perc_pkg::ST_TOO_MANY;
        err_nxt = 1'b1;
      end else begin
        st_v        = perc_pkg::ST_ACCEPTED;
        wr_en       = 1'b1;
        acc_cnt_nxt = acc_cnt_r + 1'b1;
      end
    end

    // Present the result for one cycle
    if (fin_v) begin
      state_nxt                = S_IDLE;
      out_valid_nxt            = 1'b1;
      out_nxt.status           = st_v;
      out_nxt.partition_number = (st_v == perc_pkg::ST_ACCEPTED) ? num_v : '0;
      out_nxt.stored_count     = perc_pkg::STORED_W'(acc_cnt_nxt);
    end
  end

  // Control state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      win_lo_r    <= '0;
      win_hi_r    <= '0;
      acc_cnt_r   <= '0;
      ent_cnt_r   <= '0;
      err_r       <= 1'b0;
      out_valid_r <= 1'b0;
      out_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      win_lo_r    <= win_lo_nxt;
      win_hi_r    <= win_hi_nxt;
      acc_cnt_r   <= acc_cnt_nxt;
      ent_cnt_r   <= ent_cnt_nxt;
      err_r       <= err_nxt;
      out_valid_r <= out_valid_nxt;
      out_r       <= out_nxt;
    end
  end

  // Payload, scan pointer and range store
  always_ff @(posedge clk) begin
    item_r <= item_nxt;
    scan_r <= scan_nxt;
    num_r  <= num_nxt;
    if (wr_en) begin
      rs_r[acc_cnt_r[perc_pkg::PART_IDX_W-1:0]] <= item_r.lba_lo;
      re_r[acc_cnt_r[perc_pkg::PART_IDX_W-1:0]] <= item_r.lba_hi;
    end
  end

endmodule

`default_nettype wire

@@ design/perc_checker.sv @@
`default_nettype none

module perc_checker (
  input wire                              clk,
  input wire                              rst_n,
  input wire                              start,
  input wire                              busy,
  input wire                              out_valid,
  input wire perc_pkg::out_t              out_data
);

  // A taken entry keeps the block busy in the next cycle
  a_busy_after_start: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("busy low after an entry transfer");

  // One result per entry: never two strobes back to back
  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe held for two cycles");

  // Status is always a defined code
  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.status <= perc_pkg::ST_IGNORED)
    else $error("undefined status code");

  // Accepted entries carry a number and a non-empty table
  a_accept_number: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status == perc_pkg::ST_ACCEPTED |->
      out_data.partition_number != '0 && out_data.stored_count != '0)
    else $error("accepted entry without number or stored count");

  // Anything else reports entry number zero
  a_reject_number: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status != perc_pkg::ST_ACCEPTED |->
      out_data.partition_number == '0)
    else $error("non-accepted entry reports a number");

endmodule

bind partition_entry_range_checker perc_checker u_perc_checker (.*);

`default_nettype wire

@@ tb/testbench.sv @@
`timescale 1ns / 100ps

module testbench;
  import perc_pkg::*;

  localparam logic [LBA_W-1:0]     LBA_MAX      = '1;
  localparam logic [GUID_W-1:0]    GUID_ONES    = '1;
  // indexes past the register map: writes there must be dropped
  localparam logic [CFG_IDX_W-1:0] REG_SPARE2   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE3   = 2'd3;
  localparam int                   SETTLE_TICKS = 40;
  localparam int                   QUIET_LIMIT  = 2000;

  typedef struct {
    in_t entry;
    int  hold;
  } pending_entry_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 start = 1'b0;
  logic                 busy;
  in_t                  in_data = '0;
  logic                 out_valid;
  out_t                 out_data;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [LBA_W-1:0]     cfg_wdata = '0;

  // stimulus and scoreboard
  pending_entry_t entry_queue[$];
  out_t           pending_results[$];
  int             queued_items = 0;
  int             results_seen = 0;
  int             failures = 0;
  int             hold_count = 0;
  int             quiet_cycles = 0;

  // predictor state
  logic [LBA_W-1:0] usable_lo = '0;
  logic [LBA_W-1:0] usable_hi = '0;
  logic [LBA_W-1:0] part_lo [MAX_PARTITIONS];
  logic [LBA_W-1:0] part_hi [MAX_PARTITIONS];
  int               stored_parts = 0;
  int               entry_idx = 0;
  bit               fault_latched = 1'b0;

  partition_entry_range_checker dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // Expected verdict for one entry; updates the predictor's table state
  function automatic out_t judge_entry(in_t e);
    out_t        r;
    logic [2:0]  verdict;
    r = '0;
    if (e.new_table) begin
      stored_parts  = 0;
      entry_idx     = 0;
      fault_latched = 1'b0;
    end
    if (entry_idx >= MAX_ENTRIES) begin
      // past the end of the table: counter saturates
      verdict = ST_IGNORED;
    end else begin
      entry_idx++;
      if (fault_latched) begin
        verdict = ST_IGNORED;
      end else begin
        if (e.type_guid_high == '0 && e.type_guid_low == '0) begin
          verdict = ST_EMPTY;
        end else if (e.lba_lo > e.lba_hi || e.lba_lo < usable_lo ||
                     e.lba_hi > usable_hi) begin
          verdict = ST_RANGE;
        end else begin
          verdict = ST_ACCEPTED;
          for (int k = 0; k < stored_parts; k++) begin
            if (!(e.lba_hi < part_lo[k] || e.lba_lo > part_hi[k])) verdict = ST_OVERLAP;
          end
          if (verdict == ST_ACCEPTED && stored_parts >= MAX_PARTITIONS) verdict = ST_TOO_MANY;
        end
        if (verdict == ST_ACCEPTED) begin
          part_lo[stored_parts] = e.lba_lo;
          part_hi[stored_parts] = e.lba_hi;
          stored_parts++;
          r.partition_number = entry_idx[PNUM_W-1:0];
        end else if (verdict != ST_EMPTY) begin
          fault_latched = 1'b1;
        end
      end
    end
    r.status       = verdict;
    r.stored_count = stored_parts[STORED_W-1:0];
    return r;
  endfunction

  // Driver: holds start until the transfer, then waits out the next hold
  always @(posedge clk) begin
    pending_entry_t head;
    if (!rst_n) begin
      start      <= 1'b0;
      hold_count <= 0;
    end else begin
      if (start && !busy) pending_results.push_back(judge_entry(in_data));
      if (!start || !busy) begin
        if (entry_queue.size() == 0) begin
          start <= 1'b0;
        end else if (hold_count < entry_queue[0].hold) begin
          start      <= 1'b0;
          hold_count <= hold_count + 1;
        end else begin
          head = entry_queue.pop_front();
          in_data    <= head.entry;
          start      <= 1'b1;
          hold_count <= 0;
        end
      end
    end
  end

  // Monitor: every strobe is checked against the oldest expectation
  always @(posedge clk) begin
    out_t want;
    if (rst_n && out_valid === 1'b1) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        $error("result with nothing expected: status %0d", out_data.status);
        failures++;
      end else begin
        want = pending_results.pop_front();
        if (out_data.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_data.status);
          failures++;
        end
        if (out_data.partition_number !== want.partition_number) begin
          $error("partition_number: expected %0d, got %0d", want.partition_number,
                 out_data.partition_number);
          failures++;
        end
        if (out_data.stored_count !== want.stored_count) begin
          $error("stored_count: expected %0d, got %0d", want.stored_count,
                 out_data.stored_count);
          failures++;
        end
      end
    end
  end

  // Watchdog: counts cycles with no transfer of any kind
  always @(posedge clk) begin
    if ((start && busy === 1'b0) || out_valid === 1'b1 || cfg_we) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    wait (quiet_cycles >= QUIET_LIMIT);
    $display("TEST FAILED");
    $finish;
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [LBA_W-1:0] data);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    if (idx == REG_WIN_LO) usable_lo = data;
    else if (idx == REG_WIN_HI) usable_hi = data;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic queue_entry(bit nt, logic [GUID_W-1:0] ghi, logic [GUID_W-1:0] glo,
                             logic [LBA_W-1:0] first, logic [LBA_W-1:0] last,
                             int hold = -1);
    pending_entry_t p;
    p.entry.new_table      = nt;
    p.entry.type_guid_high = ghi;
    p.entry.type_guid_low  = glo;
    p.entry.lba_lo         = first;
    p.entry.lba_hi         = last;
    p.hold = (hold < 0) ? $urandom_range(0, 7) : hold;
    entry_queue.push_back(p);
    queued_items++;
  endtask

  // Wait for every result, then let the block settle
  task automatic wait_idle();
    while (results_seen < queued_items) @(posedge clk);
    repeat (SETTLE_TICKS) @(posedge clk);
  endtask

  // One table: mostly ascending, disjoint ranges inside the usable window,
  // salted with empty entries and broken ones
  task automatic build_table(int n, int pct_empty, int pct_bad, bit steady);
    logic [63:0]      cursor, span, len, lo64, hi64;
    logic [GUID_W-1:0] ghi, glo;
    logic [LBA_W-1:0] prev_hi;
    int               pick;
    span    = (usable_hi >= usable_lo) ? 64'(usable_hi) - 64'(usable_lo) + 64'd1 : 64'd1;
    cursor  = 64'(usable_lo);
    prev_hi = usable_lo;
    for (int i = 0; i < n; i++) begin
      ghi = {$urandom, $urandom};
      glo = {$urandom, $urandom};
      // one half zero is still a live type
      case ($urandom_range(0, 9))
        0:       ghi = '0;
        1:       glo = '0;
        default: ;
      endcase
      pick = $urandom_range(0, 99);
      if (pick < pct_empty) begin
        ghi  = '0;
        glo  = '0;
        lo64 = {$urandom, $urandom};
        hi64 = {$urandom, $urandom};
      end else if (pick < pct_empty + pct_bad) begin
        case ($urandom_range(0, 4))
          0: begin  // touches the previous range
            lo64 = 64'(prev_hi);
            hi64 = 64'(prev_hi) + 64'($urandom_range(0, 3));
          end
          1: begin  // inverted
            hi64 = cursor;
            lo64 = cursor + 64'($urandom_range(1, 8));
          end
          2: begin  // starts below the window
            lo64 = 64'(usable_lo) - 64'($urandom_range(1, 4));
            hi64 = cursor;
          end
          3: begin  // ends above the window
            lo64 = cursor;
            hi64 = 64'(usable_hi) + 64'($urandom_range(1, 4));
          end
          default: begin
            lo64 = {$urandom, $urandom};
            hi64 = {$urandom, $urandom};
          end
        endcase
      end else begin
        len     = ($urandom_range(0, 4) == 0) ? 64'd0 :
                  {$urandom, $urandom} % ((span >> 6) + 64'd1);
        lo64    = cursor + 64'($urandom_range(0, 2));
        hi64    = lo64 + len;
        cursor  = hi64 + 64'd1;
        prev_hi = hi64[LBA_W-1:0];
      end
      queue_entry(i == 0 || $urandom_range(0, 99) == 0, ghi, glo, lo64[LBA_W-1:0],
                  hi64[LBA_W-1:0], steady ? 0 : $urandom_range(0, 7));
    end
  endtask

  // New window, an optional long lead table, then short mixed tables
  task automatic run_phase(logic [LBA_W-1:0] lo, logic [LBA_W-1:0] hi, int target,
                           int lead_n, int lead_empty);
    int goal;
    write_reg(REG_WIN_LO, lo);
    write_reg(REG_WIN_HI, hi);
    goal = queued_items + target;
    if (lead_n > 0) build_table(lead_n, lead_empty, 0, $urandom_range(0, 1) == 1);
    while (queued_items < goal)
      build_table($urandom_range(2, 20), 10, 12, $urandom_range(0, 3) == 0);
    wait_idle();
  endtask

  initial begin
    logic [LBA_W-1:0] rnd_lo;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // reset window is [0,0]: only a single block at zero fits
    queue_entry(1'b1, '0, '0, '0, '0);
    queue_entry(1'b0, GUID_ONES, '0, '0, '0);
    queue_entry(1'b0, '0, 64'd1, '0, '0);
    queue_entry(1'b0, GUID_ONES, GUID_ONES, LBA_MAX, LBA_MAX);
    queue_entry(1'b1, 64'd1, '0, '0, 48'd1);
    wait_idle();

    // full window, plus writes to unmapped indexes
    write_reg(REG_WIN_LO, '0);
    write_reg(REG_WIN_HI, LBA_MAX);
    write_reg(REG_SPARE2, LBA_W'({$urandom, $urandom}));
    write_reg(REG_SPARE3, LBA_W'({$urandom, $urandom}));
    queue_entry(1'b1, GUID_ONES, GUID_ONES, '0, LBA_MAX);
    queue_entry(1'b0, 64'd5, 64'd5, LBA_MAX, LBA_MAX);
    queue_entry(1'b1, 64'd5, 64'd5, 48'd5, 48'd4);
    queue_entry(1'b1, 64'd7, '0, LBA_MAX, LBA_MAX);
    queue_entry(1'b0, '0, 64'd7, '0, LBA_MAX - 1);
    queue_entry(1'b0, 64'd9, 64'd9, 48'd100, 48'd100);
    wait_idle();

    // narrow window: edges, inclusive overlap, ignored after an error
    write_reg(REG_WIN_LO, 48'd10);
    write_reg(REG_WIN_HI, 48'd20);
    queue_entry(1'b1, 64'd1, 64'd1, 48'd9, 48'd15);
    queue_entry(1'b1, 64'd1, 64'd1, 48'd10, 48'd21);
    queue_entry(1'b1, 64'd1, 64'd1, 48'd10, 48'd10);
    queue_entry(1'b0, 64'd1, 64'd1, 48'd20, 48'd20);
    queue_entry(1'b0, 64'd1, 64'd1, 48'd11, 48'd19);
    queue_entry(1'b0, '0, '0, LBA_MAX, '0);
    queue_entry(1'b0, 64'd1, 64'd1, 48'd12, 48'd12);
    queue_entry(1'b0, 64'd1, 64'd1, 48'd13, 48'd13);
    queue_entry(1'b1, 64'd2, 64'd2, '0, '0);
    wait_idle();

    // random tables over several windows; the first lead table runs past the
    // entry limit and the second fills the partition store
    run_phase('0, LBA_MAX, 180, 132, 80);
    run_phase(48'd1000, 48'd1000 + 48'h10_0000, 130, 40, 5);
    run_phase(LBA_MAX - 48'd4095, LBA_MAX, 100, 0, 0);
    rnd_lo = LBA_W'({$urandom, $urandom});
    run_phase(rnd_lo, LBA_W'(rnd_lo + {$urandom_range(0, 65535), $urandom}), 100, 0, 0);
    run_phase(48'd600, 48'd500, 40, 0, 0);
    run_phase('0, '0, 40, 0, 0);

    if (pending_results.size() != 0) begin
      $error("%0d expected results never arrived", pending_results.size());
      failures++;
    end
    if (failures == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
